### design/buddhabrot_orbit_histogram_macros.svh
// Assertion macros used by the orbit histogram top level
`ifndef BUDDHABROT_ORBIT_HISTOGRAM_MACROS_SVH
`define BUDDHABROT_ORBIT_HISTOGRAM_MACROS_SVH

// Implication checked on every clock edge outside reset
`define BOH_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("boh check failed");

// Next-cycle implication checked outside reset
`define BOH_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("boh check failed");

`endif

### design/boh_pkg.sv
// Package: shared constants and types of the orbit histogram block
`default_nettype none
package boh_pkg;
  localparam int GridSize   = 512;
  localparam int OrbitDepth = 1024;
  localparam int CountWidth = 32;
  localparam int FracBits   = 28;
  localparam int GridBits   = $clog2(GridSize);
  localparam int CellBits   = 2 * GridBits;
  localparam int Cells      = GridSize * GridSize;
  localparam int OrbitBits  = $clog2(OrbitDepth);
  localparam int StepBits   = 10;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_READ   = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  localparam logic CFG_MAX_ITER = 1'b0;
  localparam logic CFG_MIN_ITER = 1'b1;
endpackage
`default_nettype wire

### design/boh_ram.sv
// Generic single-port-write, single-read RAM with registered read data
`default_nettype none
module boh_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(Depth)-1:0] wr_addr,
  input  wire logic [Width-1:0]         wr_data,
  input  wire logic [$clog2(Depth)-1:0] rd_addr,
  output logic      [Width-1:0]         rd_data
);
  logic [Width-1:0] mem [Depth];

  // Write and read on the same edge
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

### design/buddhabrot_orbit_histogram.sv
// Top level: orbit iteration, orbit replay into the histogram memory, commands
//
// channel | handshake       | payload
// in      | in_valid/ready  | command, c_real, c_imag, read_x, read_y
// out     | out_valid/ready | escaped, accumulated, escape_step, bin_count, peak_count
// cfg     | cfg_we          | cfg_index, cfg_data
//
// Sample: a multiply and an add state per orbit step, then memory read,
// bin, histogram read and write back states per replayed orbit point.
// Read waits for the registered histogram read; clear sweeps the histogram
// memory, one bin a cycle. After reset the same clearing sweep runs before
// any word is taken. The output register holds a word until taken; the next
// word is accepted and worked on meanwhile, and its result waits behind it.
`default_nettype none
`include "buddhabrot_orbit_histogram_macros.svh"
module buddhabrot_orbit_histogram (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  command,
  input  wire logic signed [30:0] c_real,
  input  wire logic signed [30:0] c_imag,
  input  wire logic [8:0]  read_x,
  input  wire logic [8:0]  read_y,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             escaped,
  output logic             accumulated,
  output logic [9:0]       escape_step,
  output logic [31:0]      bin_count,
  output logic [31:0]      peak_count,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [9:0]  cfg_data
);
  localparam int CB = boh_pkg::CellBits;
  localparam int OB = boh_pkg::OrbitBits;
  localparam int GB = boh_pkg::GridBits;
  localparam int CW = boh_pkg::CountWidth;
  localparam int FB = boh_pkg::FracBits;

  typedef enum logic [9:0] {
    S_CLEAR  = 10'b0000000001,
    S_IDLE   = 10'b0000000010,
    S_MUL    = 10'b0000000100,
    S_ADD    = 10'b0000001000,
    S_RADDR  = 10'b0000010000,
    S_BIN    = 10'b0000100000,
    S_HREAD  = 10'b0001000000,
    S_HWRITE = 10'b0010000000,
    S_RDWAIT = 10'b0100000000,
    S_DONE   = 10'b1000000000
  } state_t;

  state_t state;
  logic [9:0] max_iter, min_iter;
  logic [1:0] cmd;
  logic signed [31:0] ca, cb, x, y;
  logic signed [63:0] pxx, pyy, pxy;
  logic [OB-1:0] step, limit, idx, q;
  logic [CB-1:0] sweep, bin_addr;
  logic cell_ok;
  logic [CW-1:0] peak;
  logic [CW-1:0] res_bin;
  logic res_esc, res_acc;
  logic [9:0] res_step;

  // Memories
  logic h_we, o_we;
  logic [CB-1:0] h_waddr, h_raddr;
  logic [CW-1:0] h_wdata, h_rdata;
  logic [OB-1:0] o_waddr, o_raddr;
  logic [63:0] o_wdata, o_rdata;

  boh_ram #(.Width(CW), .Depth(boh_pkg::Cells)) u_hist (
    .clk, .wr_en(h_we), .wr_addr(h_waddr), .wr_data(h_wdata),
    .rd_addr(h_raddr), .rd_data(h_rdata));
  boh_ram #(.Width(64), .Depth(boh_pkg::OrbitDepth)) u_orbit (
    .clk, .wr_en(o_we), .wr_addr(o_waddr), .wr_data(o_wdata),
    .rd_addr(o_raddr), .rd_data(o_rdata));

  // Orbit step arithmetic
  logic signed [63:0] nx_full, ny_full;
  logic signed [31:0] nx, ny;
  logic out_box;
  localparam logic signed [31:0] Bound = 32'sd2 <<< FB;
  always_comb begin
    nx_full = ((pxx - pyy) >>> FB) + 64'(ca);
    ny_full = ((pxy <<< 1) >>> FB) + 64'(cb);
    nx = (nx_full > 64'sh7FFFFFFF) ? 32'sh7FFFFFFF :
         (nx_full < -64'sh80000000) ? 32'sh80000000 : nx_full[31:0];
    ny = (ny_full > 64'sh7FFFFFFF) ? 32'sh7FFFFFFF :
         (ny_full < -64'sh80000000) ? 32'sh80000000 : ny_full[31:0];
    out_box = (nx < -Bound) || (nx > Bound) || (ny < -Bound) || (ny > Bound);
  end

  // Bin mapping, rounded half away from zero
  function automatic logic signed [32:0] to_bin(input logic signed [31:0] v);
    logic [31:0] m;
    logic [32:0] r;
    logic signed [32:0] s;
    m = v[31] ? 32'(-v) : 32'(v);
    r = (33'(m) + (33'd1 << (FB + 1 - GB))) >> (FB + 2 - GB);
    s = v[31] ? -$signed(r) : $signed(r);
    return s + 33'(boh_pkg::GridSize / 2);
  endfunction

  logic signed [32:0] bx, by;
  always_comb begin
    bx = to_bin(o_rdata[63:32]);
    by = to_bin(o_rdata[31:0]);
  end

  // Memory ports
  always_comb begin
    h_we = 1'b0; h_waddr = bin_addr; h_wdata = h_rdata; h_raddr = bin_addr;
    o_we = 1'b0; o_waddr = step; o_wdata = {nx, ny}; o_raddr = q;
    if (state == S_CLEAR) begin
      h_we = 1'b1; h_waddr = sweep; h_wdata = '0;
    end
    if (state == S_ADD) o_we = 1'b1;
    if (state == S_HWRITE && cell_ok) begin
      h_we = 1'b1;
      h_wdata = (h_rdata == {CW{1'b1}}) ? h_rdata : h_rdata + 1'b1;
    end
    if (state == S_IDLE) h_raddr = {read_x, read_y};
  end

  logic [CW-1:0] upd;
  assign upd = (h_rdata == {CW{1'b1}}) ? h_rdata : h_rdata + 1'b1;
  assign in_ready = (state == S_IDLE);

  // Control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR; sweep <= '0; peak <= '0; out_valid <= 1'b0;
      max_iter <= 10'd999; min_iter <= 10'd50; cmd <= boh_pkg::CMD_NONE;
    end else begin
      if (cfg_we) begin
        if (cfg_index == boh_pkg::CFG_MAX_ITER) max_iter <= cfg_data;
        else min_iter <= cfg_data;
      end
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          sweep <= sweep + 1'b1;
          if (&sweep) state <= (cmd == boh_pkg::CMD_CLEAR) ? S_DONE : S_IDLE;
        end
        S_IDLE: if (in_valid && in_ready) begin
          cmd <= command; ca <= 32'(c_real); cb <= 32'(c_imag);
          x <= '0; y <= '0; step <= '0; res_bin <= '0;
          res_esc <= 1'b0; res_acc <= 1'b0; res_step <= '0;
          limit <= (max_iter > 10'(boh_pkg::OrbitDepth - 1)) ?
                   OB'(boh_pkg::OrbitDepth - 1) : OB'(max_iter);
          unique case (boh_pkg::cmd_t'(command))
            boh_pkg::CMD_SAMPLE: state <= S_MUL;
            boh_pkg::CMD_READ:   state <= S_RDWAIT;
            boh_pkg::CMD_CLEAR: begin
              state <= S_CLEAR; sweep <= '0; peak <= '0;
            end
            default: state <= S_DONE;
          endcase
        end
        S_MUL: begin
          if (step == limit) state <= S_DONE;
          else begin
            pxx <= x * x; pyy <= y * y; pxy <= x * y; state <= S_ADD;
          end
        end
        S_ADD: begin
          x <= nx; y <= ny; step <= step + 1'b1;
          if (out_box) begin
            res_esc <= 1'b1; res_step <= 10'(step + 1'b1);
            idx <= step + 1'b1; q <= '0;
            if (10'(step + 1'b1) >= min_iter) begin
              res_acc <= 1'b1; state <= S_RADDR;
            end else state <= S_DONE;
          end else state <= S_MUL;
        end
        S_RADDR: state <= S_BIN;
        S_BIN: begin
          bin_addr <= {bx[GB-1:0], by[GB-1:0]};
          cell_ok <= (bx >= 0) && (bx < boh_pkg::GridSize) &&
                     (by >= 0) && (by < boh_pkg::GridSize);
          state <= S_HREAD;
        end
        S_HREAD: state <= S_HWRITE;
        S_HWRITE: begin
          if (cell_ok && upd > peak) peak <= upd;
          q <= q + 1'b1;
          state <= (q + 1'b1 == idx) ? S_DONE : S_RADDR;
        end
        S_RDWAIT: begin
          res_bin <= h_rdata; state <= S_DONE;
        end
        S_DONE: if (!out_valid || out_ready) begin
          out_valid <= 1'b1; escaped <= res_esc; accumulated <= res_acc;
          escape_step <= res_step; bin_count <= res_bin[31:0];
          peak_count <= peak[31:0]; cmd <= boh_pkg::CMD_NONE; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `BOH_ASSERT_IMP(a_no_take_busy, clk, rst, state != S_IDLE, !in_ready)
  `BOH_ASSERT_IMP(a_acc_esc, clk, rst, out_valid && accumulated, escaped)
  `BOH_ASSERT_IMP(a_step_esc, clk, rst, out_valid && !escaped, escape_step == 10'd0)
  `BOH_ASSERT_NXT(a_clear_peak, clk, rst, state == S_CLEAR, peak == '0)
endmodule
`default_nettype wire

### sim/buddhabrot_orbit_histogram_checker.sv
// Checker: predicts each result word of the orbit histogram block and compares it
module buddhabrot_orbit_histogram_checker
  import boh_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [1:0]  command,
  input  wire logic [30:0] c_real,
  input  wire logic [30:0] c_imag,
  input  wire logic [8:0]  read_x,
  input  wire logic [8:0]  read_y,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic        escaped,
  input  wire logic        accumulated,
  input  wire logic [9:0]  escape_step,
  input  wire logic [31:0] bin_count,
  input  wire logic [31:0] peak_count,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [9:0]  cfg_data,
  output int               fail_count,
  output int               pending,
  output int               accum_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        escaped;
    logic        accumulated;
    logic [9:0]  escape_step;
    logic [31:0] bin_count;
    logic [31:0] peak_count;
  } result_t;

  result_t     result_q[$];
  int unsigned hist_model[int];
  int unsigned peak_model;
  logic [9:0]  max_iter_model;
  logic [9:0]  min_iter_model;
  int          orbit_re[0:OrbitDepth-1];
  int          orbit_im[0:OrbitDepth-1];

  assign pending = result_q.size();

  // Saturate to a signed 32-bit value
  function automatic int sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  function automatic bit off_box(int v);
    longint bound;
    bound = longint'(2) <<< FracBits;
    return (longint'(v) < -bound) || (longint'(v) > bound);
  endfunction

  // Map one orbit coordinate onto a bin, rounding half away from zero
  function automatic longint bin_of(int v);
    longint scaled, m, q;
    scaled = longint'(v) * GridSize;
    m = (scaled < 0) ? -scaled : scaled;
    q = (m + (longint'(1) <<< (FracBits + 1))) >>> (FracBits + 2);
    return ((scaled < 0) ? -q : q) + GridSize / 2;
  endfunction

  // Iterate one point, replay its orbit into the histogram when it qualifies
  function automatic result_t run_sample(logic [30:0] cr, logic [30:0] ci);
    result_t r;
    longint  a, b, x, y, bx, by;
    int      limit, idx, bin_idx;
    r = '0;
    a = longint'($signed(cr));
    b = longint'($signed(ci));
    limit = (max_iter_model > OrbitDepth - 1) ? OrbitDepth - 1 : max_iter_model;
    idx = 0;
    orbit_re[0] = 0;
    orbit_im[0] = 0;
    for (int j = 0; j < limit; j++) begin
      x = orbit_re[j];
      y = orbit_im[j];
      orbit_re[j+1] = sat32(((x * x - y * y) >>> FracBits) + a);
      orbit_im[j+1] = sat32(((2 * x * y) >>> FracBits) + b);
      if (off_box(orbit_re[j+1]) || off_box(orbit_im[j+1])) begin
        idx = j + 1;
        break;
      end
    end
    if (idx > 0) begin
      r.escaped = 1'b1;
      r.escape_step = idx[9:0];
      if (idx >= min_iter_model) begin
        r.accumulated = 1'b1;
        for (int q = 1; q <= idx; q++) begin
          bx = bin_of(orbit_re[q]);
          by = bin_of(orbit_im[q]);
          if (bx >= 0 && bx < GridSize && by >= 0 && by < GridSize) begin
            bin_idx = int'(bx) * GridSize + int'(by);
            if (!hist_model.exists(bin_idx)) hist_model[bin_idx] = 0;
            if (hist_model[bin_idx] != 32'hffffffff) hist_model[bin_idx]++;
            if (hist_model[bin_idx] > peak_model) peak_model = hist_model[bin_idx];
          end
        end
      end
    end
    r.peak_count = peak_model;
    return r;
  endfunction

  // Predict on every accepted input word, compare on every accepted output word
  always @(posedge clk) begin
    result_t r, got;
    int      bin_idx;
    if (rst) begin
      result_q.delete();
      hist_model.delete();
      peak_model = 0;
      max_iter_model = 10'd999;
      min_iter_model = 10'd50;
      fail_count = 0;
      accum_seen = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_MAX_ITER) max_iter_model = cfg_data;
        else min_iter_model = cfg_data;
      end
      if (out_valid && out_ready) begin
        got = {escaped, accumulated, escape_step, bin_count, peak_count};
        if (result_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected output word %h", got);
        end else begin
          r = result_q.pop_front();
          if (got.accumulated) accum_seen++;
          if (got !== r) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: esc %b/%b acc %b/%b step %0d/%0d bin %0d/%0d peak %0d/%0d",
                       r.escaped, got.escaped, r.accumulated, got.accumulated,
                       r.escape_step, got.escape_step, r.bin_count, got.bin_count,
                       r.peak_count, got.peak_count);
          end
        end
      end
      if (in_valid && in_ready) begin
        r = '0;
        case (cmd_t'(command))
          CMD_SAMPLE: r = run_sample(c_real, c_imag);
          CMD_READ: begin
            bin_idx = int'(read_x) * GridSize + int'(read_y);
            if (hist_model.exists(bin_idx)) r.bin_count = hist_model[bin_idx];
            r.peak_count = peak_model;
          end
          CMD_CLEAR: begin
            hist_model.delete();
            peak_model = 0;
          end
          default: r.peak_count = peak_model;
        endcase
        result_q.push_back(r);
      end
    end
  end
endmodule

### sim/buddhabrot_orbit_histogram_tb.sv
// Testbench top: clock, reset, stimulus, flow control and verdict for the orbit histogram
module buddhabrot_orbit_histogram_tb;
  import boh_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk, rst;
  logic        in_valid, in_ready;
  logic [1:0]  command;
  logic [30:0] c_real, c_imag;
  logic [8:0]  read_x, read_y;
  logic        out_valid, out_ready;
  logic        escaped, accumulated;
  logic [9:0]  escape_step;
  logic [31:0] bin_count, peak_count;
  logic        cfg_we, cfg_index;
  logic [9:0]  cfg_data;
  int          fail_count, pending, accum_seen;
  int          words_in, stall_cycles, n_sample, n_read, n_clear, n_cfg;
  bit          hold_done;

  buddhabrot_orbit_histogram dut (.*);
  buddhabrot_orbit_histogram_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Free-running idling is off in a stretch of the run
  function automatic bit calm();
    return words_in >= 60 && words_in < 110;
  endfunction

  always @(posedge clk) begin
    if (rst) words_in <= 0;
    else if (in_valid && in_ready) words_in <= words_in + 1;
  end

  // Receiver: random stalls, one long hold-off while the sender keeps offering
  initial begin
    out_ready = 1'b0;
    hold_done = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!hold_done && words_in >= 150) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (3000) @(posedge clk);
      end
      out_ready <= calm() || ($urandom_range(99) >= 35);
    end
  end

  // Watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > 800000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_word(logic [1:0] cmd, logic [30:0] cr, logic [30:0] ci,
                           logic [8:0] rx, logic [8:0] ry);
    int gap;
    gap = 0;
    if (!calm()) while ($urandom_range(99) < 35 && gap < 12) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    command <= cmd;
    c_real <= cr;
    c_imag <= ci;
    read_x <= rx;
    read_y <= ry;
    in_valid <= 1'b1;
    case (cmd_t'(cmd))
      CMD_SAMPLE: n_sample++;
      CMD_READ:   n_read++;
      CMD_CLEAR:  n_clear++;
      default:    ;
    endcase
    do @(posedge clk); while (!in_ready);
  endtask

  // Drain the block, then write both registers
  task automatic set_limits(logic [9:0] max_it, logic [9:0] min_it);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_MAX_ITER;
    cfg_data <= max_it;
    @(posedge clk);
    cfg_index <= CFG_MIN_ITER;
    cfg_data <= min_it;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_cfg++;
  endtask

  // Sample c in [-2, 2] on both axes, one point in ten drawn from the full range
  task automatic send_point();
    logic [30:0] cr, ci;
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) begin
      cr = 31'($urandom);
      ci = 31'($urandom);
    end else begin
      cr = 31'($signed($urandom_range(1073741824)) - 536870912);
      ci = 31'($signed($urandom_range(1073741824)) - 536870912);
    end
    send_word(CMD_SAMPLE, cr, ci, 9'($urandom), 9'($urandom));
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    command = CMD_SAMPLE;
    c_real = '0;
    c_imag = '0;
    read_x = '0;
    read_y = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_MAX_ITER;
    cfg_data = '0;
    n_sample = 0;
    n_read = 0;
    n_clear = 0;
    n_cfg = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset limits, origin and the c = -2 tip never escape
    send_word(CMD_SAMPLE, 31'd0, 31'd0, 9'd0, 9'd0);
    send_word(CMD_SAMPLE, -31'sd536870912, 31'd0, 9'd0, 9'd0);
    send_word(CMD_SAMPLE, 31'sd536870912, 31'd0, 9'd511, 9'd511);
    send_word(CMD_SAMPLE, 31'h3fffffff, 31'h40000000, 9'd0, 9'd0);
    send_word(CMD_NONE, 31'h7fffffff, 31'h7fffffff, 9'd511, 9'd511);
    // Accumulate everything, deepest orbit storage
    set_limits(10'd1023, 10'd0);
    send_word(CMD_SAMPLE, 31'h40000000, 31'h3fffffff, 9'd0, 9'd0);
    send_word(CMD_SAMPLE, 31'sd100000000, 31'sd200000000, 9'd0, 9'd0);
    send_word(CMD_SAMPLE, 31'sd80000000, -31'sd300000000, 9'd0, 9'd0);
    send_word(CMD_SAMPLE, -31'sd400000000, -31'sd150000000, 9'd0, 9'd0);
    send_word(CMD_READ, 31'd0, 31'd0, 9'd0, 9'd0);
    send_word(CMD_READ, 31'd0, 31'd0, 9'd511, 9'd511);
    send_word(CMD_READ, 31'd0, 31'd0, 9'd0, 9'd511);
    send_word(CMD_READ, 31'd0, 31'd0, 9'd280, 9'd290);
    send_word(CMD_CLEAR, 31'd0, 31'd0, 9'd0, 9'd0);
    send_word(CMD_READ, 31'd0, 31'd0, 9'd280, 9'd290);
    // One step only, nothing accumulated
    set_limits(10'd1, 10'd1023);
    send_word(CMD_SAMPLE, 31'h40000000, 31'd0, 9'd0, 9'd0);
    send_word(CMD_SAMPLE, 31'd0, 31'd0, 9'd0, 9'd0);
    // No steps at all
    set_limits(10'd0, 10'd0);
    send_word(CMD_SAMPLE, 31'h40000000, 31'h40000000, 9'd0, 9'd0);
    send_word(CMD_NONE, 31'd0, 31'd0, 9'd0, 9'd0);

    // Random phases: small iteration limits but a deep last phase, reads mostly aimed at live bins
    for (int ph = 0; ph < 9; ph++) begin
      logic [9:0] mx, mn;
      mx = (ph == 8) ? 10'd1023 : 10'($urandom_range(60, 2));
      mn = (ph == 8) ? 10'd3 : 10'($urandom_range(mx / 2));
      set_limits(mx, mn);
      for (int k = 0; k < 30; k++) begin
        int sel;
        sel = $urandom_range(99);
        if (sel < 65) send_point();
        else if (sel < 92)
          send_word(CMD_READ, 31'($urandom), 31'($urandom),
                    9'($urandom_range(300, 210)), 9'($urandom_range(300, 210)));
        else if (sel < 97)
          send_word(CMD_READ, 31'($urandom), 31'($urandom), 9'($urandom), 9'($urandom));
        else if (sel < 99 || n_clear > 1)
          send_word(CMD_NONE, 31'($urandom), 31'($urandom), 9'($urandom), 9'($urandom));
        else
          send_word(CMD_CLEAR, 31'($urandom), 31'($urandom), 9'($urandom), 9'($urandom));
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Covered %0d samples (%0d accumulated), %0d reads, %0d clears, %0d limit settings",
             n_sample, accum_seen, n_read, n_clear, n_cfg);
    $display("including out-of-box points, unused commands and a long receiver hold-off");
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
